FILE: hw/rtl/pat_pkg.sv
// Shared sizes, codes and the job record for the pairwise attenuation table.
// Used by every module of the block; depends on nothing.
package pat_pkg;

   localparam int MAX_DEVICES = 16;
   localparam int DEV_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
   localparam int ADDR_W      = 2 * DEV_W;
   localparam int MEM_DEPTH   = 1 << ADDR_W;
   localparam int LOOKUP_W    = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;

   localparam int OP_W       = 2;
   localparam int ID_W       = 8;
   localparam int LEVEL_W    = 16;
   localparam int MASK_W     = 16;
   localparam int KIND_W     = 2;
   localparam int SOURCE_W   = 4;
   localparam int DCOUNT_W   = 5;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - SOURCE_W - LEVEL_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_LEVEL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_COUNT  = 1'b1;

   localparam logic [DCOUNT_W-1:0] DEVICE_COUNT_RESET = 5'd16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_RESET_ALL = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_ALL   = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_PAIR  = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

   typedef enum logic [2:0] {
      JOB_CLEAR  = 3'd0,
      JOB_ROW    = 3'd1,
      JOB_PAIR   = 3'd2,
      JOB_LOOKUP = 3'd3,
      JOB_REPLY  = 3'd4
   } job_op_type;

   typedef struct packed {
      job_op_type          op;
      logic [KIND_W-1:0]   kind;
      logic [DEV_W-1:0]    device;
      logic [DEV_W-1:0]    peer;
      logic [DEV_W-1:0]    receiver;
      logic [LEVEL_W-1:0]  level;
      logic [LOOKUP_W-1:0] mask;
      logic [CNT_W-1:0]    count;
   } job_type;

endpackage

FILE: hw/rtl/pat_front.sv
// Front end: configuration registers and classification of each request
// into a job record. Depends on pat_pkg.
module pat_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pat_pkg::OP_W-1:0]            req_tuser,
   input  logic [pat_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pat_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pat_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                queue_full,
   output logic                                push,
   output pat_pkg::job_type                    push_job
);

   logic [pat_pkg::LEVEL_W-1:0]  default_level_ff, default_level_in;
   logic [pat_pkg::DCOUNT_W-1:0] device_count_ff, device_count_in;

   logic [pat_pkg::ID_W-1:0]     device;
   logic [pat_pkg::ID_W-1:0]     peer;
   logic [pat_pkg::LEVEL_W-1:0]  level;
   logic [pat_pkg::MASK_W-1:0]   tx_mask;
   logic [pat_pkg::ID_W-1:0]     receiver;
   logic [pat_pkg::CNT_W-1:0]    active;
   logic [pat_pkg::LOOKUP_W-1:0] lim_mask;
   logic [pat_pkg::LOOKUP_W-1:0] masked;
   logic                         dev_bad;
   logic                         peer_bad;
   logic                         rx_bad;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   assign device   = req_tdata[7:0];
   assign peer     = req_tdata[15:8];
   assign level    = req_tdata[31:16];
   assign tx_mask  = req_tdata[47:32];
   assign receiver = req_tdata[55:48];

   always_comb begin
      default_level_in = default_level_ff;
      device_count_in  = device_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pat_pkg::CSR_DEFAULT_LEVEL: default_level_in = csr_data;
            pat_pkg::CSR_DEVICE_COUNT:  device_count_in  = csr_data[pat_pkg::DCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_level_ff <= '0;
         device_count_ff  <= pat_pkg::DEVICE_COUNT_RESET;
      end else begin
         default_level_ff <= default_level_in;
         device_count_ff  <= device_count_in;
      end
   end

   always_comb begin
      if (int'(device_count_ff) < pat_pkg::MAX_DEVICES) begin
         active = pat_pkg::CNT_W'(device_count_ff);
      end else begin
         active = pat_pkg::CNT_W'(pat_pkg::MAX_DEVICES);
      end
      for (int i = 0; i < pat_pkg::LOOKUP_W; i++) begin
         lim_mask[i] = (i < int'(active));
      end
      masked   = tx_mask[pat_pkg::LOOKUP_W-1:0] & lim_mask;
      dev_bad  = int'(device) >= int'(active);
      peer_bad = (int'(peer) >= int'(active)) || (peer == device);
      rx_bad   = int'(receiver) >= int'(active);
   end

   always_comb begin
      push_job          = '0;
      push_job.kind     = pat_pkg::KIND_DONE;
      push_job.device   = device[pat_pkg::DEV_W-1:0];
      push_job.peer     = peer[pat_pkg::DEV_W-1:0];
      push_job.receiver = receiver[pat_pkg::DEV_W-1:0];
      push_job.level    = level;
      push_job.mask     = masked;
      push_job.count    = active;
      unique case (req_tuser)
         pat_pkg::OP_RESET_ALL: begin
            push_job.op    = pat_pkg::JOB_CLEAR;
            push_job.level = default_level_ff;
         end
         pat_pkg::OP_SET_ALL: begin
            if (dev_bad) begin
               push_job.op   = pat_pkg::JOB_REPLY;
               push_job.kind = pat_pkg::KIND_REJECT;
            end else begin
               push_job.op = pat_pkg::JOB_ROW;
            end
         end
         pat_pkg::OP_SET_PAIR: begin
            if (dev_bad || peer_bad) begin
               push_job.op   = pat_pkg::JOB_REPLY;
               push_job.kind = pat_pkg::KIND_REJECT;
            end else begin
               push_job.op = pat_pkg::JOB_PAIR;
            end
         end
         pat_pkg::OP_LOOKUP: begin
            if (rx_bad) begin
               push_job.op   = pat_pkg::JOB_REPLY;
               push_job.kind = pat_pkg::KIND_REJECT;
            end else if (masked == '0) begin
               push_job.op   = pat_pkg::JOB_REPLY;
               push_job.kind = pat_pkg::KIND_EMPTY;
            end else begin
               push_job.op = pat_pkg::JOB_LOOKUP;
            end
         end
         default: begin
            push_job.op   = pat_pkg::JOB_REPLY;
            push_job.kind = pat_pkg::KIND_REJECT;
         end
      endcase
   end

endmodule

FILE: hw/rtl/pat_queue.sv
// Short job queue between the front end and the table engine.
// Depends on pat_pkg for the job record and depth.
module pat_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pat_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output pat_pkg::job_type pop_job,
   output logic             empty
);

   pat_pkg::job_type            slots_ff [pat_pkg::QUEUE_DEPTH];
   logic [pat_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pat_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pat_pkg::QCNT_W-1:0]  fill_ff, fill_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (fill_ff == pat_pkg::QCNT_W'(pat_pkg::QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         if (wr_ptr_ff == pat_pkg::QPTR_W'(pat_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + pat_pkg::QPTR_W'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == pat_pkg::QPTR_W'(pat_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + pat_pkg::QPTR_W'(1);
         end
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + pat_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - pat_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= pat_pkg::QUEUE_DEPTH)
      else $error("queue fill above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (fill_ff == $past(fill_ff) + pat_pkg::QCNT_W'(1)))
      else $error("queue fill missed a push");

endmodule

FILE: hw/rtl/pat_back.sv
// Table engine: holds the attenuation memory, runs write sweeps and lookup
// scans from the job queue, and drives the response register. Depends on pat_pkg.
module pat_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  pat_pkg::job_type                   job,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pat_pkg::KIND_W-1:0]         rsp_tuser,
   output logic [pat_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WRITE  = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   pat_pkg::job_type             job_ff, job_in;
   logic [pat_pkg::DEV_W-1:0]    cnt_ff, cnt_in;
   logic                         phase_ff, phase_in;
   logic [pat_pkg::LOOKUP_W-1:0] mask_ff, mask_in;

   logic [pat_pkg::LEVEL_W-1:0]  loss_mem_ff [pat_pkg::MEM_DEPTH];
   logic [pat_pkg::MEM_DEPTH-1:0] valid_ff;
   logic [pat_pkg::LEVEL_W-1:0]  fill_ff;
   logic [pat_pkg::LEVEL_W-1:0]  mem_q_ff;
   logic                         rd_hit_ff;

   logic                         rd_valid_ff, rd_valid_in;
   logic [pat_pkg::DEV_W-1:0]    rd_src_ff, rd_src_in;
   logic                         rd_last_ff, rd_last_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pat_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [pat_pkg::SOURCE_W-1:0] rsp_source_ff, rsp_source_in;
   logic [pat_pkg::LEVEL_W-1:0]  rsp_loss_ff, rsp_loss_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         out_free;
   logic                         wr_en;
   logic [pat_pkg::ADDR_W-1:0]   wr_addr;
   logic                         rd_en;
   logic [pat_pkg::ADDR_W-1:0]   rd_addr;
   logic                         clear;
   logic                         step_end;
   logic [pat_pkg::DEV_W-1:0]    pick;
   logic [pat_pkg::LOOKUP_W-1:0] mask_rest;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{pat_pkg::RSP_PAD_W{1'b0}}, rsp_loss_ff, rsp_source_ff};

   always_comb begin
      pick = '0;
      for (int i = pat_pkg::LOOKUP_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = pat_pkg::DEV_W'(i);
         end
      end
      mask_rest = mask_ff & (mask_ff - pat_pkg::LOOKUP_W'(1));
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      cnt_in        = cnt_ff;
      phase_in      = phase_ff;
      mask_in       = mask_ff;
      pop           = 1'b0;
      clear         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = {job_ff.device, cnt_ff};
      rd_en         = 1'b0;
      rd_addr       = {pick, job_ff.receiver};
      step_end      = 1'b0;
      rd_valid_in   = rd_valid_ff;
      rd_src_in     = rd_src_ff;
      rd_last_in    = rd_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_source_in = rsp_source_ff;
      rsp_loss_in   = rsp_loss_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (rd_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = pat_pkg::KIND_ENTRY;
         rsp_source_in = pat_pkg::SOURCE_W'(rd_src_ff);
         rsp_loss_in   = rd_hit_ff ? mem_q_ff : fill_ff;
         rsp_last_in   = rd_last_ff;
         rd_valid_in   = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               job_in   = job;
               cnt_in   = '0;
               phase_in = 1'b0;
               unique case (job.op) inside
                  pat_pkg::JOB_CLEAR: begin
                     clear    = 1'b1;
                     state_in = ST_FINISH;
                  end
                  pat_pkg::JOB_ROW, pat_pkg::JOB_PAIR: state_in = ST_WRITE;
                  pat_pkg::JOB_LOOKUP: begin
                     mask_in  = job.mask;
                     state_in = ST_LOOKUP;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (job_ff.op == pat_pkg::JOB_ROW) begin
               wr_addr  = phase_ff ? {cnt_ff, job_ff.device} : {job_ff.device, cnt_ff};
               step_end = (cnt_ff == pat_pkg::DEV_W'(job_ff.count - pat_pkg::CNT_W'(1)));
            end else begin
               wr_addr  = phase_ff ? {job_ff.peer, job_ff.device}
                                   : {job_ff.device, job_ff.peer};
               step_end = 1'b1;
            end
            if (step_end) begin
               cnt_in = '0;
               if (phase_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + pat_pkg::DEV_W'(1);
            end
         end
         ST_LOOKUP: begin
            if ((mask_ff != '0) && (!rd_valid_ff || out_free)) begin
               rd_en       = 1'b1;
               mask_in     = mask_rest;
               rd_valid_in = 1'b1;
               rd_src_in   = pick;
               rd_last_in  = (mask_rest == '0);
            end else if ((mask_ff == '0) && !rd_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = job_ff.kind;
               rsp_source_in = '0;
               rsp_loss_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear) begin
            valid_ff <= '0;
            fill_ff  <= job.level;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      cnt_ff        <= cnt_in;
      phase_ff      <= phase_in;
      mask_ff       <= mask_in;
      rd_src_ff     <= rd_src_in;
      rd_last_ff    <= rd_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_source_ff <= rsp_source_in;
      rsp_loss_ff   <= rsp_loss_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         loss_mem_ff[wr_addr] <= job_ff.level;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff  <= loss_mem_ff[rd_addr];
         rd_hit_ff <= valid_ff[rd_addr];
      end
   end

   a_read_in_lookup: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_LOOKUP))
      else $error("read stage busy outside a lookup");

   a_last_drains_mask: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_last_ff) |-> (mask_ff == '0))
      else $error("last entry issued with mask bits left");

   a_finish_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("single reply not loaded on finish");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE && !rd_valid_ff))
      else $error("job popped while engine busy");

endmodule

FILE: hw/rtl/pairwise_attenuation_table_unit.sv
// Top level of the pairwise attenuation table: front end, job queue and
// table engine. Depends on pat_pkg, pat_front, pat_queue and pat_back.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser op, tdata device..receiver
//   rsp      out  rsp_tvalid/rsp_tready  tuser kind, tdata source/loss, tlast
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// Each request runs as steps in the table engine: set-all writes the
// device's row and then its column, set-pair writes both entries of the
// pair, and lookup reads one entry per set mask bit. Reset-all needs no
// clearing pass: per-entry valid bits stand in for one. A stalled response
// holds its register; the queue keeps accepting up to two requests.
module pairwise_attenuation_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pat_pkg::OP_W-1:0]          req_tuser,  // op
   // device[7:0], peer[15:8], level[31:16], tx_mask[47:32], receiver[55:48]
   input  logic [pat_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pat_pkg::KIND_W-1:0]        rsp_tuser,  // kind
   // source[3:0], loss[19:4], zero pad[23:20]
   output logic [pat_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,  // final_res
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pat_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pat_pkg::CSR_DATA_W-1:0]    csr_data
);

   pat_pkg::job_type push_job;
   pat_pkg::job_type pop_job;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;

   pat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   pat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   pat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (!queue_empty),
      .job        (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
